[design/bounded_rgba_over_compositor_top_assert.svh]
// Assertion macros shared by the compositor checker.
`ifndef BOUNDED_RGBA_OVER_COMPOSITOR_TOP_ASSERT_SVH
`define BOUNDED_RGBA_OVER_COMPOSITOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define BRGBA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("compositor check failed");

// Implication across the pipeline depth.
`define BRGBA_ASSERT_LAT2(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error("compositor latency check failed");

`endif

[design/brgba_pkg.sv]
// Shared types, constants and register codes of the RGBA compositor.
`timescale 1ns / 1ps
package brgba_pkg;

   localparam int COORD_BITS     = 12;
   localparam int CHAN_BITS      = 8;
   localparam int NUM_LANES      = 4;
   localparam int CSR_INDEX_BITS = 4;
   localparam int PROD_BITS      = 2 * CHAN_BITS;

   // Register indexes on the CSR port
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_COL_LO = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_COL_HI = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_ROW_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_A_ROW_HI = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_COL_LO = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_COL_HI = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_ROW_LO = CSR_INDEX_BITS'(6);
   localparam logic [CSR_INDEX_BITS-1:0] REG_B_ROW_HI = CSR_INDEX_BITS'(7);

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = {CHAN_BITS{1'b1}};

   typedef enum logic [2:0] {
      REGION_UNTOUCHED  = 3'd0,
      REGION_ZEROED     = 3'd1,
      REGION_COPIED_B   = 3'd2,
      REGION_KEPT_A     = 3'd3,
      REGION_COMPOSITED = 3'd4
   } region_type;

   // What the merge stage puts out
   typedef enum logic [1:0] {
      SEL_A,
      SEL_B,
      SEL_ZERO,
      SEL_BLEND
   } sel_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] col_lo;
      logic [COORD_BITS-1:0] col_hi;
      logic [COORD_BITS-1:0] row_lo;
      logic [COORD_BITS-1:0] row_hi;
   } rect_type;

   localparam rect_type RECT_RESET = '{
      col_lo: COORD_BITS'(1),
      col_hi: COORD_BITS'(0),
      row_lo: COORD_BITS'(1),
      row_hi: COORD_BITS'(0)
   };

   // Classifier decision, carried down the pipe
   typedef struct packed {
      region_type region;
      sel_type    sel;
   } class_type;

   typedef logic [NUM_LANES-1:0][CHAN_BITS-1:0] pixel_type;

endpackage

[design/brgba_classify.sv]
// Position classifier: rectangle tests, region code and output select.
`timescale 1ns / 1ps
module brgba_classify (
   input  brgba_pkg::rect_type                     a_rect,
   input  brgba_pkg::rect_type                     b_rect,
   input  logic                                    action,
   input  logic [brgba_pkg::COORD_BITS-1:0]        col,
   input  logic [brgba_pkg::COORD_BITS-1:0]        row,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         a_alpha,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         b_alpha,
   output brgba_pkg::class_type                    decision
);
   import brgba_pkg::*;

   logic                  a_empty;
   logic                  b_empty;
   logic                  in_a;
   logic                  in_b;
   logic                  in_union;
   logic [COORD_BITS-1:0] u_col_lo;
   logic [COORD_BITS-1:0] u_col_hi;
   logic [COORD_BITS-1:0] u_row_lo;
   logic [COORD_BITS-1:0] u_row_hi;

   // Rectangle membership
   always_comb begin
      a_empty = (a_rect.col_lo > a_rect.col_hi) || (a_rect.row_lo > a_rect.row_hi);
      b_empty = (b_rect.col_lo > b_rect.col_hi) || (b_rect.row_lo > b_rect.row_hi);
      in_a = !a_empty && (col >= a_rect.col_lo) && (col <= a_rect.col_hi) &&
             (row >= a_rect.row_lo) && (row <= a_rect.row_hi);
      in_b = !b_empty && (col >= b_rect.col_lo) && (col <= b_rect.col_hi) &&
             (row >= b_rect.row_lo) && (row <= b_rect.row_hi);
   end

   // Union box of both rectangles
   always_comb begin
      u_col_lo = (a_rect.col_lo < b_rect.col_lo) ? a_rect.col_lo : b_rect.col_lo;
      u_col_hi = (a_rect.col_hi > b_rect.col_hi) ? a_rect.col_hi : b_rect.col_hi;
      u_row_lo = (a_rect.row_lo < b_rect.row_lo) ? a_rect.row_lo : b_rect.row_lo;
      u_row_hi = (a_rect.row_hi > b_rect.row_hi) ? a_rect.row_hi : b_rect.row_hi;
      in_union = (col >= u_col_lo) && (col <= u_col_hi) &&
                 (row >= u_row_lo) && (row <= u_row_hi);
   end

   // Region and select
   always_comb begin
      decision.region = REGION_UNTOUCHED;
      decision.sel    = SEL_A;
      if (a_empty) begin
         if (in_b) begin
            decision.region = REGION_COPIED_B;
            decision.sel    = SEL_B;
         end
      end else if (b_empty) begin
         if (in_a) begin
            decision.region = REGION_KEPT_A;
         end
      end else if (in_a && in_b) begin
         decision.region = REGION_COMPOSITED;
         // a transparent front passes the back pixel
         if (!action) begin
            decision.sel = (a_alpha == '0) ? SEL_B : SEL_BLEND;
         end else begin
            decision.sel = (b_alpha == '0) ? SEL_A : SEL_BLEND;
         end
      end else if (in_b) begin
         decision.region = REGION_COPIED_B;
         decision.sel    = SEL_B;
      end else if (in_a) begin
         decision.region = REGION_KEPT_A;
      end else if (in_union) begin
         decision.region = REGION_ZEROED;
         decision.sel    = SEL_ZERO;
      end
   end

endmodule

[design/brgba_lane.sv]
// One channel lane: front + floor(back*(255-alpha)/255), saturated.
`timescale 1ns / 1ps
module brgba_lane (
   input  logic                               clock,
   input  logic                               load,
   input  logic [brgba_pkg::CHAN_BITS-1:0]    front,
   input  logic [brgba_pkg::CHAN_BITS-1:0]    back,
   input  logic [brgba_pkg::CHAN_BITS-1:0]    alpha,
   output logic [brgba_pkg::CHAN_BITS-1:0]    blended
);
   import brgba_pkg::*;

   logic [PROD_BITS-1:0] prod_in;
   logic [PROD_BITS-1:0] prod_ff;
   logic [CHAN_BITS-1:0] front_ff;
   logic [PROD_BITS-1:0] bias;
   logic [PROD_BITS-1:0] quot_sum;
   logic [CHAN_BITS:0]   total;

   // Multiply back by the inverse alpha
   assign prod_in = back * (CHAN_MAX - alpha);

   // Hold product and front for the second stage
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff  <= prod_in;
         front_ff <= front;
      end
   end

   // Divide by 255: (x + 1 + (x >> 8)) >> 8 is exact for x up to 255*255
   always_comb begin
      bias     = prod_ff >> CHAN_BITS;
      quot_sum = prod_ff + bias + PROD_BITS'(1);
      total    = {1'b0, front_ff} + {1'b0, quot_sum[PROD_BITS-1:CHAN_BITS]};
      blended  = total[CHAN_BITS] ? CHAN_MAX : total[CHAN_BITS-1:0];
   end

endmodule

[design/bounded_rgba_over_compositor_top.sv]
// Top level of the bounded premultiplied RGBA over compositor.
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+---------------------------------------
//   req      | start / busy         | action, col, row, A and B RGBA pixels
//   rsp      | rsp_valid (strobe)   | out RGBA pixel, region code
//   csr      | csr_valid/csr_ready  | csr_index, csr_data (bound register)
//
// One pixel enters every cycle; busy stays low. Each result passes the lane
// multiplier register, then the divide-by-255, merge and output register,
// before it shows on the ports. Reset clears the bound registers to empty
// rectangles and the pipeline valids. The receiver cannot stall; each
// result shows for one cycle. csr_ready is always high.
`timescale 1ns / 1ps
module bounded_rgba_over_compositor_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // request
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_action,
   input  logic [brgba_pkg::COORD_BITS-1:0]        req_col,
   input  logic [brgba_pkg::COORD_BITS-1:0]        req_row,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_red,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_green,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_blue,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_alpha,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_red,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_green,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_blue,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_alpha,
   // response
   output logic                                    rsp_valid,
   output logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_red,
   output logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_green,
   output logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_blue,
   output logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_alpha,
   output logic [2:0]                              rsp_region,
   // configuration
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [brgba_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [brgba_pkg::COORD_BITS-1:0]        csr_data
);
   import brgba_pkg::*;

   rect_type  a_rect_ff;
   rect_type  a_rect_in;
   rect_type  b_rect_ff;
   rect_type  b_rect_in;
   logic      accept;
   pixel_type a_pix;
   pixel_type b_pix;
   pixel_type front_pix;
   pixel_type back_pix;
   pixel_type blend_pix;
   pixel_type a_pix_ff;
   pixel_type b_pix_ff;
   pixel_type out_pix_in;
   pixel_type out_pix_ff;
   logic [CHAN_BITS-1:0] front_alpha;
   class_type decision;
   class_type s1_class_ff;
   logic      s1_valid_ff;
   logic      rsp_valid_ff;
   region_type region_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Decode CSR writes into the bound registers
   always_comb begin
      a_rect_in = a_rect_ff;
      b_rect_in = b_rect_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_A_COL_LO: a_rect_in.col_lo = csr_data;
            REG_A_COL_HI: a_rect_in.col_hi = csr_data;
            REG_A_ROW_LO: a_rect_in.row_lo = csr_data;
            REG_A_ROW_HI: a_rect_in.row_hi = csr_data;
            REG_B_COL_LO: b_rect_in.col_lo = csr_data;
            REG_B_COL_HI: b_rect_in.col_hi = csr_data;
            REG_B_ROW_LO: b_rect_in.row_lo = csr_data;
            REG_B_ROW_HI: b_rect_in.row_hi = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rect_ff <= RECT_RESET;
         b_rect_ff <= RECT_RESET;
      end else begin
         a_rect_ff <= a_rect_in;
         b_rect_ff <= b_rect_in;
      end
   end

   // Gather the pixels, channel 0 red through channel 3 alpha
   assign a_pix = {req_a_alpha, req_a_blue, req_a_green, req_a_red};
   assign b_pix = {req_b_alpha, req_b_blue, req_b_green, req_b_red};

   brgba_classify u_classify (
      .a_rect   (a_rect_ff),
      .b_rect   (b_rect_ff),
      .action   (req_action),
      .col      (req_col),
      .row      (req_row),
      .a_alpha  (req_a_alpha),
      .b_alpha  (req_b_alpha),
      .decision (decision)
   );

   // Pick front and back for the blend
   assign front_pix   = req_action ? b_pix : a_pix;
   assign back_pix    = req_action ? a_pix : b_pix;
   assign front_alpha = req_action ? req_b_alpha : req_a_alpha;

   for (genvar lane = 0; lane < NUM_LANES; lane++) begin : g_lane
      brgba_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .front   (front_pix[lane]),
         .back    (back_pix[lane]),
         .alpha   (front_alpha),
         .blended (blend_pix[lane])
      );
   end

   // Stage one: hold the decision and the raw pixels next to the lanes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_class_ff <= decision;
         a_pix_ff    <= a_pix;
         b_pix_ff    <= b_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Merge the lanes with the pass-through cases
   always_comb begin
      case (s1_class_ff.sel)
         SEL_B:     out_pix_in = b_pix_ff;
         SEL_ZERO:  out_pix_in = '0;
         SEL_BLEND: out_pix_in = blend_pix;
         default:   out_pix_in = a_pix_ff;
      endcase
   end

   // Stage two: output register
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         out_pix_ff <= out_pix_in;
         region_ff  <= s1_class_ff.region;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_pix_ff[0];
   assign rsp_out_green = out_pix_ff[1];
   assign rsp_out_blue  = out_pix_ff[2];
   assign rsp_out_alpha = out_pix_ff[3];
   assign rsp_region    = region_ff;

endmodule

[design/brgba_checker.sv]
// Port-level checker for the compositor, bound to the top level.
`timescale 1ns / 1ps
`include "bounded_rgba_over_compositor_top_assert.svh"
module brgba_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic                                    req_action,
   input  logic [brgba_pkg::COORD_BITS-1:0]        req_col,
   input  logic [brgba_pkg::COORD_BITS-1:0]        req_row,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_red,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_green,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_blue,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_a_alpha,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_red,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_green,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_blue,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         req_b_alpha,
   input  logic                                    rsp_valid,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_red,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_green,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_blue,
   input  logic [brgba_pkg::CHAN_BITS-1:0]         rsp_out_alpha,
   input  logic [2:0]                              rsp_region,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [brgba_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [brgba_pkg::COORD_BITS-1:0]        csr_data
);
   import brgba_pkg::*;

   // Every taken beat gives a result through both pipeline valid registers
   `BRGBA_ASSERT_LAT2(a_req_to_rsp, start && !busy, rsp_valid)

   // No result without a taken beat behind it in the pipeline
   `BRGBA_ASSERT_NOW(a_rsp_from_req, rsp_valid, $past(start && !busy, 2))

   // Zeroed positions give a transparent black pixel
   `BRGBA_ASSERT_NOW(a_zeroed_black, rsp_valid && rsp_region == REGION_ZEROED,
      rsp_out_red == '0 && rsp_out_green == '0 && rsp_out_blue == '0 && rsp_out_alpha == '0)

   // Untouched positions return the A pixel as it came in
   `BRGBA_ASSERT_NOW(a_untouched_keeps_a, rsp_valid && rsp_region == REGION_UNTOUCHED,
      rsp_out_red == $past(req_a_red, 2) && rsp_out_green == $past(req_a_green, 2) &&
      rsp_out_blue == $past(req_a_blue, 2) && rsp_out_alpha == $past(req_a_alpha, 2))

endmodule

bind bounded_rgba_over_compositor_top brgba_checker u_checker (.*);
